[rtl/dxad_pkg.sv]
// Shared constants, codes and types for the XOR-hash DRAM address decoder.
package dxad_pkg;

    localparam int MAX_SELECT_BITS = 4;
    localparam int ADDR_BITS       = 64;
    localparam int WORD_BITS       = 64;
    localparam int FIELD_COUNT     = 4;
    localparam int SLOT_COUNT      = FIELD_COUNT * MAX_SELECT_BITS;
    localparam int SLOT_IDX_BITS   = $clog2(SLOT_COUNT);
    localparam int INDEX_BITS      = 4;
    localparam int COUNT_BITS      = 3;
    localparam int LANE_BITS       = 8;
    localparam int LANES           = WORD_BITS / LANE_BITS;

    localparam logic [WORD_BITS-1:0] ADDR_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - ADDR_BITS);

    localparam logic CMD_DECODE     = 1'b0;
    localparam logic CMD_WRITE_SLOT = 1'b1;

    localparam int FIELD_CHANNEL = 0;
    localparam int FIELD_RANK    = 1;
    localparam int FIELD_GROUP   = 2;
    localparam int FIELD_BANK    = 3;

    typedef enum logic [2:0] {
        CFG_CHANNEL_COUNT = 3'd0,
        CFG_RANK_COUNT    = 3'd1,
        CFG_GROUP_COUNT   = 3'd2,
        CFG_BANK_COUNT    = 3'd3,
        CFG_ROW_MASK      = 3'd4,
        CFG_COLUMN_MASK   = 3'd5
    } t_cfg_index;

    typedef logic [WORD_BITS-1:0]       t_word;
    typedef logic [MAX_SELECT_BITS-1:0] t_field;

endpackage

[rtl/dxad_gather.sv]
// Three-stage pipelined bit gather: compresses the address bits picked by a mask LSB-first.
module dxad_gather (
    input  logic               i_clk,
    input  dxad_pkg::t_word    i_addr,
    input  dxad_pkg::t_word    i_sel,
    output dxad_pkg::t_word    o_value
);

    localparam int WB    = dxad_pkg::WORD_BITS;
    localparam int LB    = dxad_pkg::LANE_BITS;
    localparam int NL    = dxad_pkg::LANES;
    localparam int CNT_W = $clog2(LB + 1);
    localparam int POS_W = $clog2(LB);
    localparam int OFF_W = $clog2(WB + 1);

    logic [LB-1:0]    r_pack1 [NL];
    logic [LB-1:0]    n_pack1 [NL];
    logic [CNT_W-1:0] r_cnt1  [NL];
    logic [CNT_W-1:0] n_cnt1  [NL];
    logic [LB-1:0]    r_pack2 [NL];
    logic [OFF_W-1:0] r_off2  [NL];
    logic [OFF_W-1:0] n_off2  [NL];
    logic [WB-1:0]    r_value3;
    logic [WB-1:0]    n_value3;

    always_comb begin
        logic [CNT_W-1:0] pos;
        for (int l = 0; l < NL; l++) begin
            n_pack1[l] = '0;
            pos        = '0;
            for (int b = 0; b < LB; b++) begin
                if (i_sel[l*LB + b]) begin
                    n_pack1[l][pos[POS_W-1:0]] = i_addr[l*LB + b];
                    pos = pos + 1'b1;
                end
            end
            n_cnt1[l] = pos;
        end
    end

    always_comb begin
        logic [OFF_W-1:0] off;
        off = '0;
        for (int l = 0; l < NL; l++) begin
            n_off2[l] = off;
            off = off + OFF_W'(r_cnt1[l]);
        end
    end

    always_comb begin
        n_value3 = '0;
        for (int l = 0; l < NL; l++) begin
            n_value3 = n_value3 | (WB'(r_pack2[l]) << r_off2[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack1  <= n_pack1;
        r_cnt1   <= n_cnt1;
        r_pack2  <= r_pack1;
        r_off2   <= n_off2;
        r_value3 <= n_value3;
    end

    assign o_value = r_value3;

endmodule

[rtl/dram_xor_address_decoder.sv]
// XOR-hash DRAM address decoder: parity selectors, row and column gather, pair classification.
// An accepted decode beat passes through the valid registers r_v0 to r_v3 and drives its result strobe for one cycle.
// Throughput is one command per cycle; busy never rises and write beats give no result.
// Mask slot writes take effect for a decode beat accepted in the very next cycle.
// Synchronous active-low reset clears the pipeline valid bits, the configuration registers and the mask table.
module dram_xor_address_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_command,
    input  logic [63:0]                     i_addr_a,
    input  logic [63:0]                     i_addr_b,
    input  logic [3:0]                      i_slot_index,
    input  logic [63:0]                     i_slot_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    output logic                            o_result_valid,
    output logic [3:0]                      o_channel_index,
    output logic [3:0]                      o_rank_index,
    output logic [3:0]                      o_group_index,
    output logic [3:0]                      o_bank_index,
    output logic [63:0]                     o_row_number,
    output logic [63:0]                     o_column_number,
    output logic                            o_row_conflict,
    output logic                            o_other_group
);

    localparam int NS   = dxad_pkg::SLOT_COUNT;
    localparam int NF   = dxad_pkg::FIELD_COUNT;
    localparam int MSB  = dxad_pkg::MAX_SELECT_BITS;
    localparam int NL   = dxad_pkg::LANES;
    localparam int LB   = dxad_pkg::LANE_BITS;
    localparam int IDXW = dxad_pkg::INDEX_BITS;
    localparam int CW   = dxad_pkg::COUNT_BITS;
    localparam int SW   = dxad_pkg::SLOT_IDX_BITS;

    logic accept;

    dxad_pkg::t_word  r_masks [NS];
    logic [CW-1:0]    r_bit_count [NF];
    dxad_pkg::t_word  r_row_select;
    dxad_pkg::t_word  r_col_mask;

    logic             r_v0, r_v1, r_v2, r_v3;
    dxad_pkg::t_word  r_a0, r_d0;
    logic [NL-1:0]    r_pa1 [NS];
    logic [NL-1:0]    n_pa1 [NS];
    logic [NL-1:0]    r_pd1 [NS];
    logic [NL-1:0]    n_pd1 [NS];
    logic             r_rowdiff1, r_rowdiff2;
    dxad_pkg::t_field r_fv2 [NF];
    dxad_pkg::t_field n_fv2 [NF];
    logic [NF-1:0]    r_fm2, n_fm2;
    logic [IDXW-1:0]  r_idx3 [NF];
    logic             r_conflict3, r_other3;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_masks[s] <= '0;
            end
        end else if (accept && i_command == dxad_pkg::CMD_WRITE_SLOT
                     && int'(i_slot_index) < NS) begin
            r_masks[i_slot_index[SW-1:0]] <= i_slot_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NF; f++) begin
                r_bit_count[f] <= '0;
            end
            r_row_select <= '0;
            r_col_mask   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dxad_pkg::CFG_CHANNEL_COUNT: begin
                    r_bit_count[dxad_pkg::FIELD_CHANNEL] <= i_cfg_data[CW-1:0];
                end
                dxad_pkg::CFG_RANK_COUNT: begin
                    r_bit_count[dxad_pkg::FIELD_RANK] <= i_cfg_data[CW-1:0];
                end
                dxad_pkg::CFG_GROUP_COUNT: begin
                    r_bit_count[dxad_pkg::FIELD_GROUP] <= i_cfg_data[CW-1:0];
                end
                dxad_pkg::CFG_BANK_COUNT: begin
                    r_bit_count[dxad_pkg::FIELD_BANK] <= i_cfg_data[CW-1:0];
                end
                dxad_pkg::CFG_ROW_MASK: begin
                    r_row_select <= i_cfg_data;
                end
                dxad_pkg::CFG_COLUMN_MASK: begin
                    r_col_mask <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage one reduces each masked address to one parity bit per byte lane.
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < NL; l++) begin
                n_pa1[s][l] = ^(r_a0[l*LB +: LB] & r_masks[s][l*LB +: LB]);
                n_pd1[s][l] = ^(r_d0[l*LB +: LB] & r_masks[s][l*LB +: LB]);
            end
        end
    end

    // Stage two folds the lane parities, applies the saturated bit counts and sets the per-field match flags.
    always_comb begin
        logic pa;
        logic pd;
        logic en;
        for (int f = 0; f < NF; f++) begin
            n_fv2[f] = '0;
            n_fm2[f] = 1'b1;
            for (int i = 0; i < MSB; i++) begin
                pa = ^r_pa1[f*MSB + i];
                pd = ^r_pd1[f*MSB + i];
                en = int'(r_bit_count[f]) > i;
                n_fv2[f][i] = pa & en;
                if (pd && en) begin
                    n_fm2[f] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= accept && i_command == dxad_pkg::CMD_DECODE;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0        <= i_addr_a & dxad_pkg::ADDR_MASK;
        r_d0        <= (i_addr_a ^ i_addr_b) & dxad_pkg::ADDR_MASK;
        r_pa1       <= n_pa1;
        r_pd1       <= n_pd1;
        r_rowdiff1  <= |(r_d0 & r_row_select);
        r_fv2       <= n_fv2;
        r_fm2       <= n_fm2;
        r_rowdiff2  <= r_rowdiff1;
        for (int f = 0; f < NF; f++) begin
            r_idx3[f] <= IDXW'(r_fv2[f]);
        end
        r_conflict3 <= (&r_fm2) && r_rowdiff2;
        r_other3    <= r_fm2[dxad_pkg::FIELD_CHANNEL] && r_fm2[dxad_pkg::FIELD_RANK]
                       && !r_fm2[dxad_pkg::FIELD_GROUP];
    end

    dxad_gather u_row_gather (
        .i_clk   (i_clk),
        .i_addr  (r_a0),
        .i_sel   (r_row_select),
        .o_value (o_row_number)
    );

    dxad_gather u_col_gather (
        .i_clk   (i_clk),
        .i_addr  (r_a0),
        .i_sel   (r_col_mask),
        .o_value (o_column_number)
    );

    assign o_result_valid  = r_v3;
    assign o_channel_index = r_idx3[dxad_pkg::FIELD_CHANNEL];
    assign o_rank_index    = r_idx3[dxad_pkg::FIELD_RANK];
    assign o_group_index   = r_idx3[dxad_pkg::FIELD_GROUP];
    assign o_bank_index    = r_idx3[dxad_pkg::FIELD_BANK];
    assign o_row_conflict  = r_conflict3;
    assign o_other_group   = r_other3;

endmodule
